FILE: rtl/assert_macros.svh
// assertion helpers included by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/cbm_pkg.sv
package cbm_pkg;

  localparam int CNT_W       = 34;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int MOD_STEPS   = 8;

  localparam logic [15:0] ADDR_PRG0     = 16'h8000;
  localparam logic [15:0] ADDR_PRG1     = 16'ha000;
  localparam logic [15:0] ADDR_PRG2     = 16'hc000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9001;
  localparam logic [15:0] ADDR_IRQ_EN   = 16'h9003;
  localparam logic [15:0] ADDR_RELOAD   = 16'h9004;
  localparam logic [15:0] ADDR_LATCH_HI = 16'h9005;
  localparam logic [15:0] ADDR_LATCH_LO = 16'h9006;
  localparam logic [15:0] ADDR_CHR_LO   = 16'hb000;
  localparam logic [15:0] ADDR_CHR_HI   = 16'hb007;

  localparam logic [3:0] SLOT_NONE   = 4'd0;
  localparam logic [3:0] SLOT_PRG0   = 4'd1;
  localparam logic [3:0] SLOT_CHR0   = 4'd4;
  localparam logic [3:0] SLOT_MIRROR = 4'd12;

  localparam logic [0:0] REG_PRG_COUNT = 1'b0;
  localparam logic [0:0] REG_CHR_COUNT = 1'b1;

  localparam logic [8:0]  PRG_COUNT_RESET = 9'd2;
  localparam logic [10:0] CHR_COUNT_RESET = 11'd8;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_PRG,
    CMD_CHR,
    CMD_MIRROR,
    CMD_IRQ_EN,
    CMD_RELOAD,
    CMD_LATCH_HI,
    CMD_LATCH_LO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] idx;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       irq;
    logic [3:0] slot;
    logic [7:0] bank;
    logic       mirror;
  } res_t;

  typedef enum logic [0:0] {
    B_IDLE,
    B_DIV
  } back_state_t;

endpackage

FILE: rtl/cbm_front.sv
module cbm_front import cbm_pkg::*; (
  input  logic        in_valid,
  input  logic        q_full,
  input  logic        mode,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        in_ready,
  output logic        push,
  output cmd_t        cmd
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.kind = CMD_NONE;
    cmd.idx  = 3'd0;
    cmd.data = data;
    if (mode) begin
      cmd.kind = CMD_TICK;
    end else begin
      case (address)
        ADDR_PRG0: begin
          cmd.kind = CMD_PRG;
          cmd.idx  = 3'd0;
        end
        ADDR_PRG1: begin
          cmd.kind = CMD_PRG;
          cmd.idx  = 3'd1;
        end
        ADDR_PRG2: begin
          cmd.kind = CMD_PRG;
          cmd.idx  = 3'd2;
        end
        ADDR_MIRROR:   cmd.kind = CMD_MIRROR;
        ADDR_IRQ_EN:   cmd.kind = CMD_IRQ_EN;
        ADDR_RELOAD:   cmd.kind = CMD_RELOAD;
        ADDR_LATCH_HI: cmd.kind = CMD_LATCH_HI;
        ADDR_LATCH_LO: cmd.kind = CMD_LATCH_LO;
        default: begin
          if (address inside {[ADDR_CHR_LO:ADDR_CHR_HI]}) begin
            cmd.kind = CMD_CHR;
            cmd.idx  = address[2:0];
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/cbm_queue.sv
module cbm_queue import cbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/cbm_modu.sv
module cbm_modu import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  dividend,
  input  logic [10:0] divisor,
  output logic [7:0]  rem,
  output logic        rem_valid
);

  logic        busy;
  logic [2:0]  cnt;
  logic [7:0]  quo;
  logic [10:0] div;
  logic [7:0]  rem_next;
  logic [8:0]  r_shift;
  logic [10:0] r_sub;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    r_shift = {rem, quo[7]};
    r_sub   = {2'b00, r_shift} - div;
    if ({2'b00, r_shift} >= div) begin
      rem_next = r_sub[7:0];
    end else begin
      rem_next = r_shift[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rem_valid <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      rem_valid <= 1'b0;
      cnt       <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == 3'(MOD_STEPS - 1)) begin
        busy      <= 1'b0;
        rem_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      div <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[6:0], 1'b0};
    end
  end

endmodule

FILE: rtl/cbm_back.sv
module cbm_back import cbm_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int LINE_STEP = 29098
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [8:0]  prg_count,
  input  logic [10:0] chr_count,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  input  logic        out_ready,
  output logic        res_valid,
  output res_t        res
);

  localparam longint LIMIT_L = longint'(LINE_STEP) - (longint'(4) << FRAC_BITS);
  localparam longint PARK_L  = longint'(16'hffff) << FRAC_BITS;
  localparam logic signed [CNT_W-1:0] LIMIT  = CNT_W'(LIMIT_L);
  localparam logic signed [CNT_W-1:0] PARK   = CNT_W'(PARK_L);
  localparam logic signed [CNT_W-1:0] STEP_C = CNT_W'(LINE_STEP);

  back_state_t state, state_next;
  cmd_t        cur;

  logic                    mirror_flag;
  logic                    irq_enable;
  logic [15:0]             irq_latch;
  logic signed [CNT_W-1:0] irq_count;

  logic        out_free;
  logic        needs_div;
  logic        mod_start;
  logic        res_load;
  logic        fire;
  logic [10:0] divisor;
  logic [7:0]  rem;
  logic        rem_valid;
  res_t        res_next;

  assign out_free  = !res_valid || out_ready;
  assign needs_div = (q_cmd.kind == CMD_PRG && prg_count != '0) ||
                     (q_cmd.kind == CMD_CHR && chr_count != '0);
  assign divisor   = (q_cmd.kind == CMD_PRG) ? {2'b00, prg_count} : chr_count;
  assign fire      = irq_enable && (irq_count < LIMIT);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid && out_free && needs_div) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (rem_valid && out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mod_start = 1'b0;
    res_load  = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop     = q_valid && out_free;
        mod_start = q_valid && out_free && needs_div;
        res_load  = q_valid && out_free && !needs_div;
      end
      B_DIV: begin
        res_load = rem_valid && out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_next.irq    = 1'b0;
    res_next.slot   = SLOT_NONE;
    res_next.bank   = 8'd0;
    res_next.mirror = mirror_flag;
    if (state == B_DIV) begin
      res_next.bank = rem;
      if (cur.kind == CMD_PRG) begin
        res_next.slot = SLOT_PRG0 + {1'b0, cur.idx};
      end else begin
        res_next.slot = SLOT_CHR0 + {1'b0, cur.idx};
      end
    end else begin
      case (q_cmd.kind)
        CMD_TICK:   res_next.irq = fire;
        CMD_MIRROR: begin
          res_next.slot   = SLOT_MIRROR;
          res_next.mirror = q_cmd.data[7];
        end
        default:    res_next.irq = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      res_valid   <= 1'b0;
      mirror_flag <= 1'b0;
      irq_enable  <= 1'b0;
      irq_latch   <= '0;
      irq_count   <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      if (q_pop) begin
        case (q_cmd.kind)
          CMD_TICK: begin
            if (fire) begin
              irq_enable <= 1'b0;
              irq_count  <= PARK;
            end else if (irq_enable) begin
              irq_count <= irq_count - STEP_C;
            end
          end
          CMD_MIRROR:   mirror_flag     <= q_cmd.data[7];
          CMD_IRQ_EN:   irq_enable      <= q_cmd.data[7];
          CMD_RELOAD:   irq_count       <= CNT_W'(irq_latch) << FRAC_BITS;
          CMD_LATCH_HI: irq_latch[15:8] <= q_cmd.data;
          CMD_LATCH_LO: irq_latch[7:0]  <= q_cmd.data;
          default:      irq_latch       <= irq_latch;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  cbm_modu u_modu (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (q_cmd.data),
    .divisor   (divisor),
    .rem       (rem),
    .rem_valid (rem_valid)
  );

endmodule

FILE: rtl/cartridge_bank_mapper_with_line_irq_core.sv
// channel  | handshake               | payload
// input    | in_valid / in_ready     | mode, address, data
// result   | out_valid / out_ready   | irq_request, slot_written, bank_number,
//          |                         | mirror_horizontal
// config   | cfg_we                  | cfg_index, cfg_data
//
// bank writes with a nonzero count pass the queue, the remainder unit (one data bit
// a cycle) and the result register; the next one starts after the last result loads
// all others retire one per cycle unless stalled, through queue and result register
// a two-entry queue takes input beats while the back end works or the result stalls
// rst is synchronous: clears queue, result, irq state and mirroring; counts go to 2 and 8
`include "assert_macros.svh"

module cartridge_bank_mapper_with_line_irq_core import cbm_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int LINE_STEP = 29098
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        irq_request,
  output logic [3:0]  slot_written,
  output logic [7:0]  bank_number,
  output logic        mirror_horizontal,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [8:0]  prg_count;
  logic [10:0] chr_count;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_cmd;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count <= PRG_COUNT_RESET;
      chr_count <= CHR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRG_COUNT: prg_count <= cfg_data[8:0];
        REG_CHR_COUNT: chr_count <= cfg_data;
        default:       prg_count <= prg_count;
      endcase
    end
  end

  cbm_front u_front (
    .in_valid (in_valid),
    .q_full   (q_full),
    .mode     (mode),
    .address  (address),
    .data     (data),
    .in_ready (in_ready),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  cbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  cbm_back #(
    .FRAC_BITS (FRAC_BITS),
    .LINE_STEP (LINE_STEP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .prg_count (prg_count),
    .chr_count (chr_count),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .res_valid (out_valid),
    .res       (res)
  );

  assign irq_request       = res.irq;
  assign slot_written      = res.slot;
  assign bank_number       = res.bank;
  assign mirror_horizontal = res.mirror;

  `ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_pop_has_room, q_pop |-> (q_valid && (!out_valid || out_ready)), "pop without room")
  `ASSERT_CLK(a_irq_no_slot, (out_valid && irq_request) |-> (slot_written == SLOT_NONE), "irq on a write")
  `ASSERT_CLK(a_bank_zero, (out_valid && (slot_written == SLOT_NONE || slot_written == SLOT_MIRROR)) |-> (bank_number == 8'd0), "stray bank")

endmodule

FILE: test/cartridge_bank_mapper_with_line_irq_core_test.sv
module cartridge_bank_mapper_with_line_irq_core_test;
  import cbm_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LINE_STEP = 29098;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic signed [33:0] LINE_LIMIT  = LINE_STEP - (4 << FRAC_BITS);
  localparam logic signed [33:0] LINE_STEP_W = LINE_STEP;
  localparam logic signed [33:0] PARK_COUNT  = 34'h0ffff << FRAC_BITS;

  localparam int NUM_ROWS   = 24;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 215;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic        m;
    logic [15:0] a;
    logic [7:0]  d;
    logic        typed;
    res_t        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [15:0] address = 16'd0;
  logic [7:0]  data = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        irq_request;
  logic [3:0]  slot_written;
  logic [7:0]  bank_number;
  logic        mirror_horizontal;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_PRG_COUNT;
  logic [10:0] cfg_data = 11'd0;

  // mapper state as the predictor sees it
  logic [8:0]         prg_count;
  logic [10:0]        chr_count;
  logic [8:0]         prg_slot [3];
  logic [10:0]        chr_slot [8];
  logic               mirror_q;
  logic               irq_on;
  logic [15:0]        latch_q;
  logic signed [33:0] line_count;

  res_t result_q [$];
  res_t head;
  int   error_count = 0;
  int   item_count = 0;
  int   result_count = 0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;

  // directed items on the reset counts (2 program banks, 8 pattern banks)
  row_t dir_rows [NUM_ROWS] = '{
    '{MODE_TICK,  16'hffff,      8'hff, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_PRG0,     8'hff, 1'b1, '{1'b0, SLOT_PRG0, 8'd1, 1'b0}},
    '{MODE_WRITE, ADDR_PRG1,     8'h00, 1'b1, '{1'b0, SLOT_PRG0 + 4'd1, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_PRG2,     8'hfe, 1'b1, '{1'b0, SLOT_PRG0 + 4'd2, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_CHR_LO,   8'hff, 1'b1, '{1'b0, SLOT_CHR0, 8'd7, 1'b0}},
    '{MODE_WRITE, ADDR_CHR_HI,   8'h0d, 1'b1, '{1'b0, SLOT_CHR0 + 4'd7, 8'd5, 1'b0}},
    '{MODE_WRITE, ADDR_CHR_LO + 16'd3, 8'h80, 1'b1,
      '{1'b0, SLOT_CHR0 + 4'd3, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_MIRROR,   8'h80, 1'b1, '{1'b0, SLOT_MIRROR, 8'd0, 1'b1}},
    '{MODE_WRITE, ADDR_CHR_HI + 16'd1, 8'hff, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b1}},
    '{MODE_WRITE, 16'h0000,      8'h00, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b1}},
    '{MODE_WRITE, ADDR_MIRROR + 16'd1, 8'hff, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b1}},
    '{MODE_WRITE, ADDR_MIRROR,   8'h7f, 1'b1, '{1'b0, SLOT_MIRROR, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_LATCH_HI, 8'h00, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_LATCH_LO, 8'h00, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_RELOAD,   8'h00, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_IRQ_EN,   8'h80, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_TICK,  16'h0000,      8'h00, 1'b1, '{1'b1, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_TICK,  16'hffff,      8'hff, 1'b1, '{1'b0, SLOT_NONE, 8'd0, 1'b0}},
    '{MODE_WRITE, ADDR_LATCH_LO, 8'h6e, 1'b0, '0},
    '{MODE_WRITE, ADDR_RELOAD,   8'hff, 1'b0, '0},
    '{MODE_WRITE, ADDR_IRQ_EN,   8'hff, 1'b0, '0},
    '{MODE_TICK,  16'h8000,      8'h00, 1'b0, '0},
    '{MODE_TICK,  16'h0000,      8'hff, 1'b0, '0},
    '{MODE_WRITE, ADDR_IRQ_EN,   8'h7f, 1'b0, '0}
  };

  int prg_set [NUM_PHASES] = '{510, 0, 3, 255, 256, 2, 7, 200};
  int chr_set [NUM_PHASES] = '{2040, 0, 13, 256, 255, 1, 2040, 8};

  logic [15:0] near_miss [6] = '{ADDR_CHR_HI + 16'd1, ADDR_MIRROR - 16'd1,
                                  ADDR_LATCH_LO + 16'd1, ADDR_PRG0 - 16'd1,
                                  ADDR_PRG2 + 16'd1, ADDR_CHR_LO - 16'd1};
  logic [15:0] irq_regs [4] = '{ADDR_IRQ_EN, ADDR_RELOAD, ADDR_LATCH_HI, ADDR_LATCH_LO};

  cartridge_bank_mapper_with_line_irq_core #(
    .FRAC_BITS(FRAC_BITS),
    .LINE_STEP(LINE_STEP)
  ) i_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

  task automatic reset_mapper_state();
    prg_count = PRG_COUNT_RESET;
    chr_count = CHR_COUNT_RESET;
    prg_slot[0] = 9'd0;
    prg_slot[1] = 9'd1;
    prg_slot[2] = prg_count - 9'd2;
    for (int i = 0; i < 8; i++) chr_slot[i] = 11'(i);
    mirror_q = 1'b0;
    irq_on = 1'b0;
    latch_q = 16'd0;
    line_count = '0;
  endtask

  function automatic res_t mapper_step(input logic m, input logic [15:0] a,
                                       input logic [7:0] d);
    res_t       r;
    logic [1:0] pi;
    logic [8:0] pb;
    logic [10:0] cb;
    r = '0;
    if (m == MODE_TICK) begin
      if (irq_on) begin
        if (line_count < LINE_LIMIT) begin
          r.irq = 1'b1;
          irq_on = 1'b0;
          line_count = PARK_COUNT;
        end else begin
          line_count = line_count - LINE_STEP_W;
        end
      end
    end else if (a == ADDR_PRG0 || a == ADDR_PRG1 || a == ADDR_PRG2) begin
      if (prg_count != 9'd0) begin
        pi = (a == ADDR_PRG0) ? 2'd0 : (a == ADDR_PRG1) ? 2'd1 : 2'd2;
        pb = {1'b0, d} % prg_count;
        prg_slot[pi] = pb;
        r.slot = SLOT_PRG0 + 4'(pi);
        r.bank = pb[7:0];
      end
    end else if (a >= ADDR_CHR_LO && a <= ADDR_CHR_HI) begin
      if (chr_count != 11'd0) begin
        cb = {3'b0, d} % chr_count;
        chr_slot[a[2:0]] = cb;
        r.slot = SLOT_CHR0 + 4'(a[2:0]);
        r.bank = cb[7:0];
      end
    end else if (a == ADDR_MIRROR) begin
      mirror_q = d[7];
      r.slot = SLOT_MIRROR;
    end else if (a == ADDR_IRQ_EN) begin
      irq_on = d[7];
    end else if (a == ADDR_RELOAD) begin
      line_count = 34'(latch_q) << FRAC_BITS;
    end else if (a == ADDR_LATCH_HI) begin
      latch_q[15:8] = d;
    end else if (a == ADDR_LATCH_LO) begin
      latch_q[7:0] = d;
    end
    r.mirror = mirror_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("mismatch at result %0d, %s: got 'h%0h, want 'h%0h",
               result_count, what, got, want);
    error_count++;
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic push_item(input logic m, input logic [15:0] a, input logic [7:0] d,
                           input logic typed, input res_t want);
    res_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    data <= d;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    pred = mapper_step(m, a, d);
    result_q.push_back(typed ? want : pred);
    item_count++;
  endtask

  task automatic send(input logic m, input logic [15:0] a, input logic [7:0] d);
    push_item(m, a, d, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_counts(input logic [8:0] prg, input logic [10:0] chr);
    cfg_we <= 1'b1;
    cfg_index <= REG_PRG_COUNT;
    cfg_data <= {2'b0, prg};
    @(posedge clk);
    cfg_index <= REG_CHR_COUNT;
    cfg_data <= chr;
    @(posedge clk);
    cfg_we <= 1'b0;
    prg_count = prg;
    chr_count = chr;
  endtask

  task automatic random_burst();
    int         r;
    int         n;
    logic [7:0] hi;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      case ($urandom_range(0, 2))
        0: send(MODE_WRITE, ADDR_PRG0, 8'($urandom));
        1: send(MODE_WRITE, ADDR_PRG1, 8'($urandom));
        default: send(MODE_WRITE, ADDR_PRG2, 8'($urandom));
      endcase
    end else if (r < 50) begin
      send(MODE_WRITE, ADDR_CHR_LO | 16'($urandom_range(0, 7)), 8'($urandom));
    end else if (r < 58) begin
      send(MODE_WRITE, ADDR_MIRROR, 8'($urandom));
    end else if (r < 72) begin
      // load latch, reload, enable, then a random run of ticks, with an odd random write
      hi = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      send(MODE_WRITE, ADDR_LATCH_HI, hi);
      send(MODE_WRITE, ADDR_LATCH_LO, 8'($urandom));
      send(MODE_WRITE, ADDR_RELOAD, 8'($urandom));
      send(MODE_WRITE, ADDR_IRQ_EN, 8'($urandom) | 8'h80);
      n = $urandom_range(1, 40);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) send(MODE_WRITE, 16'($urandom), 8'($urandom));
        else send(MODE_TICK, 16'($urandom), 8'($urandom));
      end
    end else if (r < 85) begin
      send(MODE_TICK, 16'($urandom), 8'($urandom));
    end else if (r < 91) begin
      send(MODE_WRITE, near_miss[$urandom_range(0, 5)], 8'($urandom));
    end else if (r < 96) begin
      send(MODE_WRITE, irq_regs[$urandom_range(0, 3)], 8'($urandom));
    end else begin
      send(MODE_WRITE, 16'($urandom), 8'($urandom));
    end
  endtask

  // result side: random stall bursts while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // handshake is sampled mid-cycle, the beat moves at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        head = result_q.pop_front();
        if (irq_request !== head.irq)
          report_mismatch("irq_request", irq_request, head.irq);
        if (slot_written !== head.slot)
          report_mismatch("slot_written", slot_written, head.slot);
        if (bank_number !== head.bank)
          report_mismatch("bank_number", bank_number, head.bank);
        if (mirror_horizontal !== head.mirror)
          report_mismatch("mirror_horizontal", mirror_horizontal, head.mirror);
      end
      result_count++;
    end
  end

  initial begin
    int target;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    reset_mapper_state();

    for (int i = 0; i < NUM_ROWS; i++)
      push_item(dir_rows[i].m, dir_rows[i].a, dir_rows[i].d, dir_rows[i].typed,
                dir_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      // no idle gaps or stalls in one phase in the middle and in the last phase
      idle_on = (ph != 3 && ph != NUM_PHASES - 1);
      set_counts(9'(prg_set[ph]), 11'(chr_set[ph]));
      target = item_count + PHASE_ITEMS;
      while (item_count < target) random_burst();
    end

    drain();
    if (error_count == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
